### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
// Each use expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition never holds outside reset.
`define TSA_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

### rtl/core/tsa_pkg.sv
package tsa_pkg;

	localparam int SLOTS     = 3;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PHASE_W   = $clog2(SLOTS + 1);
	localparam int FREE_W    = $clog2(SLOTS + 1);
	localparam int ADDR_W    = 64;
	localparam int MISS_W    = 4;
	localparam int SEQ_W     = 8;
	localparam int MODE_W    = 2;
	localparam int CMD_W     = 2;
	localparam int EV_W      = 2;
	localparam int EV_SLOT_W = 2;

	localparam logic [MISS_W-1:0] MISS_LIMIT_RST = 4'd3;
	localparam logic [MISS_W-1:0] MISS_MAX       = 4'd15;

	// Input item kinds
	localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_OUTCOME = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE  = 2'd2;

	// Frame commands
	localparam logic [CMD_W-1:0] FRAME_NEW    = 2'd0;
	localparam logic [CMD_W-1:0] FRAME_UPDATE = 2'd1;
	localparam logic [CMD_W-1:0] FRAME_DELETE = 2'd2;

	// Event kinds
	localparam logic [EV_W-1:0] EV_NEW     = 2'd0;
	localparam logic [EV_W-1:0] EV_UPDATE  = 2'd1;
	localparam logic [EV_W-1:0] EV_REMOVED = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TICK_DISC,
		OP_TICK_SLOT,
		OP_OUT_DISC,
		OP_OUT_SLOT,
		OP_DELETE
	} op_t;

	typedef struct packed {
		logic              load;
		op_t               op;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic [SLOTS-1:0]  occ;
		logic [FREE_W-1:0] free_cnt;
	} stat_t;

	typedef struct packed {
		logic                 send_frame;
		logic [CMD_W-1:0]     frame_command;
		logic [ADDR_W-1:0]    target_address;
		logic [SEQ_W-1:0]     sequence_number;
		logic                 event_valid;
		logic [EV_W-1:0]      event_kind;
		logic [ADDR_W-1:0]    event_address;
		logic [EV_SLOT_W-1:0] event_slot;
		logic                 occupied_indicator;
	} result_t;

endpackage

### rtl/core/tsa_cfg_if.sv
interface tsa_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tsa_pkg::MISS_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/tsa_in_if.sv
interface tsa_in_if;
	logic                        valid;
	logic                        ready;
	logic [tsa_pkg::MODE_W-1:0]  mode;
	logic                        exchange_ok;
	logic [tsa_pkg::ADDR_W-1:0]  responder_address;
	logic [tsa_pkg::ADDR_W-1:0]  delete_target;

	modport source (
		output valid, output mode, output exchange_ok,
		output responder_address, output delete_target,
		input ready
	);
	modport sink (
		input valid, input mode, input exchange_ok,
		input responder_address, input delete_target,
		output ready
	);
endinterface

### rtl/core/tsa_out_if.sv
interface tsa_out_if;
	logic                           valid;
	logic                           ready;
	logic                           send_frame;
	logic [tsa_pkg::CMD_W-1:0]      frame_command;
	logic [tsa_pkg::ADDR_W-1:0]     target_address;
	logic [tsa_pkg::SEQ_W-1:0]      sequence_number;
	logic                           event_valid;
	logic [tsa_pkg::EV_W-1:0]       event_kind;
	logic [tsa_pkg::ADDR_W-1:0]     event_address;
	logic [tsa_pkg::EV_SLOT_W-1:0]  event_slot;
	logic                           occupied_indicator;

	modport source (
		output valid, output send_frame, output frame_command, output target_address,
		output sequence_number, output event_valid, output event_kind,
		output event_address, output event_slot, output occupied_indicator,
		input ready
	);
	modport sink (
		input valid, input send_frame, input frame_command, input target_address,
		input sequence_number, input event_valid, input event_kind,
		input event_address, input event_slot, input occupied_indicator,
		output ready
	);
endinterface

### rtl/core/tsa_ctrl.sv
module tsa_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [tsa_pkg::MODE_W-1:0]  mode,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  tsa_pkg::stat_t              stat,
	output tsa_pkg::cmd_t               cmd
);

	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_FULL  = 2'b10
	} state_t;

	state_t                          state_q, state_n;
	logic [tsa_pkg::PHASE_W-1:0]     phase_q, phase_n, phase_adv;
	logic                            await_q, await_n;
	logic [tsa_pkg::SLOT_W-1:0]      slot_idx;
	logic                            accept;

	assign in_ready  = (state_q == ST_EMPTY) || out_ready;
	assign out_valid = (state_q == ST_FULL);
	assign accept    = in_valid && in_ready;

	// Slot phases run 1..SLOTS; the value at phase 0 is never used.
	assign slot_idx  = tsa_pkg::SLOT_W'(phase_q - tsa_pkg::PHASE_W'(1));
	assign phase_adv = (phase_q >= tsa_pkg::PHASE_W'(tsa_pkg::SLOTS)) ?
		'0 : phase_q + tsa_pkg::PHASE_W'(1);

	always_comb begin
		state_n = state_q;
		if (accept) begin
			state_n = ST_FULL;
		end else if (out_ready) begin
			state_n = ST_EMPTY;
		end
	end

	always_comb begin
		cmd.load = accept;
		cmd.op   = tsa_pkg::OP_NONE;
		cmd.slot = slot_idx;
		phase_n  = phase_q;
		await_n  = await_q;
		if (accept) begin
			case (mode)
				tsa_pkg::MODE_TICK: begin
					if (!await_q) begin
						if (phase_q == '0) begin
							cmd.op = tsa_pkg::OP_TICK_DISC;
							if (stat.free_cnt != '0) begin
								await_n = 1'b1;
							end else begin
								phase_n = phase_adv;
							end
						end else if (stat.occ[slot_idx]) begin
							cmd.op  = tsa_pkg::OP_TICK_SLOT;
							await_n = 1'b1;
						end else begin
							phase_n = phase_adv;
						end
					end
				end
				tsa_pkg::MODE_OUTCOME: begin
					if (await_q) begin
						await_n = 1'b0;
						cmd.op  = (phase_q == '0) ? tsa_pkg::OP_OUT_DISC : tsa_pkg::OP_OUT_SLOT;
						phase_n = phase_adv;
					end
				end
				tsa_pkg::MODE_DELETE: begin
					cmd.op = tsa_pkg::OP_DELETE;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
			phase_q <= '0;
			await_q <= 1'b0;
		end else begin
			state_q <= state_n;
			phase_q <= phase_n;
			await_q <= await_n;
		end
	end

endmodule

### rtl/core/tsa_dp.sv
module tsa_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tsa_pkg::cmd_t               cmd,
	input  logic                        cfg_we,
	input  logic [tsa_pkg::MISS_W-1:0]  cfg_data,
	input  logic                        exchange_ok,
	input  logic [tsa_pkg::ADDR_W-1:0]  responder_address,
	input  logic [tsa_pkg::ADDR_W-1:0]  delete_target,
	output tsa_pkg::stat_t              stat,
	output tsa_pkg::result_t            res_q
);

	logic [tsa_pkg::MISS_W-1:0]  limit_q;
	logic [tsa_pkg::SLOTS-1:0]   occ_q, occ_n;
	logic [tsa_pkg::SLOTS-1:0]   mark_q, mark_n;
	logic [tsa_pkg::ADDR_W-1:0]  tag_q [tsa_pkg::SLOTS];
	logic [tsa_pkg::ADDR_W-1:0]  tag_n [tsa_pkg::SLOTS];
	logic [tsa_pkg::MISS_W-1:0]  miss_q [tsa_pkg::SLOTS];
	logic [tsa_pkg::MISS_W-1:0]  miss_n [tsa_pkg::SLOTS];
	logic [tsa_pkg::FREE_W-1:0]  free_q, free_n;
	logic [tsa_pkg::SEQ_W-1:0]   fc_q, fc_n;
	logic                        ind_q, ind_n;
	tsa_pkg::result_t            res_n;

	logic [tsa_pkg::SLOTS-1:0]   resp_match, del_match;
	logic [tsa_pkg::SLOT_W:0]    slot_num;
	logic [tsa_pkg::MISS_W-1:0]  miss_inc;
	logic                        found;

	assign stat.occ      = occ_q;
	assign stat.free_cnt = free_q;
	assign slot_num      = {1'b0, cmd.slot} + {{tsa_pkg::SLOT_W{1'b0}}, 1'b1};

	always_comb begin
		for (int i = 0; i < tsa_pkg::SLOTS; i++) begin
			resp_match[i] = occ_q[i] && (tag_q[i] == responder_address);
			del_match[i]  = occ_q[i] && (tag_q[i] == delete_target);
		end
	end

	always_comb begin
		occ_n    = occ_q;
		mark_n   = mark_q;
		tag_n    = tag_q;
		miss_n   = miss_q;
		free_n   = free_q;
		fc_n     = fc_q;
		ind_n    = ind_q;
		res_n    = '0;
		found    = 1'b0;
		miss_inc = miss_q[cmd.slot];
		case (cmd.op)
			tsa_pkg::OP_TICK_DISC: begin
				ind_n = (free_q != tsa_pkg::FREE_W'(tsa_pkg::SLOTS));
				if (free_q != '0) begin
					res_n.send_frame      = 1'b1;
					res_n.frame_command   = tsa_pkg::FRAME_NEW;
					res_n.sequence_number = fc_q;
					fc_n                  = fc_q + tsa_pkg::SEQ_W'(1);
				end
			end
			tsa_pkg::OP_TICK_SLOT: begin
				res_n.send_frame      = 1'b1;
				res_n.frame_command   = mark_q[cmd.slot] ?
					tsa_pkg::FRAME_DELETE : tsa_pkg::FRAME_UPDATE;
				res_n.target_address  = tag_q[cmd.slot];
				res_n.sequence_number = fc_q;
				fc_n                  = fc_q + tsa_pkg::SEQ_W'(1);
			end
			tsa_pkg::OP_OUT_DISC: begin
				// Drop duplicates, else claim the lowest free slot.
				if (exchange_ok && (resp_match == '0)) begin
					for (int i = 0; i < tsa_pkg::SLOTS; i++) begin
						if (!found && !occ_q[i]) begin
							found     = 1'b1;
							occ_n[i]  = 1'b1;
							tag_n[i]  = responder_address;
							miss_n[i] = '0;
							mark_n[i] = 1'b0;
						end
					end
					if (found) begin
						if (free_q != '0) begin
							free_n = free_q - tsa_pkg::FREE_W'(1);
						end
						res_n.event_valid   = 1'b1;
						res_n.event_kind    = tsa_pkg::EV_NEW;
						res_n.event_address = responder_address;
					end
				end
			end
			tsa_pkg::OP_OUT_SLOT: begin
				if (occ_q[cmd.slot]) begin
					if (exchange_ok) begin
						miss_n[cmd.slot] = '0;
						if (mark_q[cmd.slot]) begin
							occ_n[cmd.slot]  = 1'b0;
							mark_n[cmd.slot] = 1'b0;
							free_n           = free_q + tsa_pkg::FREE_W'(1);
						end else begin
							res_n.event_valid   = 1'b1;
							res_n.event_kind    = tsa_pkg::EV_UPDATE;
							res_n.event_address = tag_q[cmd.slot];
							res_n.event_slot    = slot_num[tsa_pkg::EV_SLOT_W-1:0];
						end
					end else begin
						if (miss_q[cmd.slot] != tsa_pkg::MISS_MAX) begin
							miss_inc = miss_q[cmd.slot] + tsa_pkg::MISS_W'(1);
						end
						miss_n[cmd.slot] = miss_inc;
						if (miss_inc >= limit_q) begin
							// Report the tag before the slot is cleared.
							res_n.event_valid   = 1'b1;
							res_n.event_kind    = tsa_pkg::EV_REMOVED;
							res_n.event_address = tag_q[cmd.slot];
							res_n.event_slot    = slot_num[tsa_pkg::EV_SLOT_W-1:0];
							occ_n[cmd.slot]     = 1'b0;
							mark_n[cmd.slot]    = 1'b0;
							miss_n[cmd.slot]    = '0;
							free_n              = free_q + tsa_pkg::FREE_W'(1);
						end
					end
				end
			end
			tsa_pkg::OP_DELETE: begin
				for (int i = 0; i < tsa_pkg::SLOTS; i++) begin
					if (!found && del_match[i]) begin
						found     = 1'b1;
						mark_n[i] = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		res_n.occupied_indicator = ind_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= tsa_pkg::MISS_LIMIT_RST;
			occ_q   <= '0;
			free_q  <= tsa_pkg::FREE_W'(tsa_pkg::SLOTS);
			fc_q    <= '0;
			ind_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.load) begin
				occ_q  <= occ_n;
				free_q <= free_n;
				fc_q   <= fc_n;
				ind_q  <= ind_n;
			end
		end
	end

	// Tag, miss count and mark are only read for occupied slots.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mark_q <= mark_n;
			tag_q  <= tag_n;
			miss_q <= miss_n;
			res_q  <= res_n;
		end
	end

endmodule

### rtl/core/tdma_slot_allocator_core.sv
// Round-robin TDMA slot scheduler: a discovery phase followed by one phase per tag slot.
// Channels:
//   req - input items: a tick that opens the current phase, an exchange outcome
//         (ok flag and responder address), or a delete request for a tag address.
//   rsp - one result per input item: frame to send (command, target, sequence
//         number), an optional event report, and the occupancy indicator.
//   cfg - write of miss_limit, always ready; write only while the block is idle.
// A result appears on rsp in the cycle after its req transfer, from the output register.
// Throughput: one item per cycle while rsp takes results; every item is handled in a
// single pass through the slot-table datapath (parallel address compare over all slots).
// The output register holds a result until rsp transfers it; req.ready stays high
// while the register is empty or is being drained the same cycle, so a stalled
// receiver back-pressures the sender after one item.
// Reset (arst_n low) empties the output register, frees all slots, returns to the
// discovery phase, clears the sequence counter and indicator, and sets
// miss_limit to 3.
`include "assert_macros.svh"

module tdma_slot_allocator_core (
	input  logic          clk,
	input  logic          arst_n,
	tsa_cfg_if.sink       cfg,
	tsa_in_if.sink        req,
	tsa_out_if.source     rsp
);

	tsa_pkg::cmd_t     cmd;
	tsa_pkg::stat_t    stat;
	tsa_pkg::result_t  res_q;

	// Take every configuration write at once.
	assign cfg.ready = 1'b1;

	tsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.mode      (req.mode),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tsa_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg_we            (cfg.valid),
		.cfg_data          (cfg.data),
		.exchange_ok       (req.exchange_ok),
		.responder_address (req.responder_address),
		.delete_target     (req.delete_target),
		.stat              (stat),
		.res_q             (res_q)
	);

	// Drive the result channel from the output register.
	assign rsp.send_frame         = res_q.send_frame;
	assign rsp.frame_command      = res_q.frame_command;
	assign rsp.target_address     = res_q.target_address;
	assign rsp.sequence_number    = res_q.sequence_number;
	assign rsp.event_valid        = res_q.event_valid;
	assign rsp.event_kind         = res_q.event_kind;
	assign rsp.event_address      = res_q.event_address;
	assign rsp.event_slot         = res_q.event_slot;
	assign rsp.occupied_indicator = res_q.occupied_indicator;

	// A transfer on req always leaves a result waiting on rsp next cycle.
	`TSA_ASSERT(a_result_follows, req.valid && req.ready |=> rsp.valid, "result missing after transfer")
	// Free count tracks the occupancy vector.
	`TSA_ASSERT(a_free_count, stat.free_cnt == tsa_pkg::FREE_W'(tsa_pkg::SLOTS - $countones(stat.occ)), "free count out of step")
	// A tick result never carries an event, an outcome never sends a frame.
	`TSA_ASSERT_NEVER(a_frame_xor_event, rsp.valid && rsp.send_frame && rsp.event_valid, "frame and event together")

endmodule

### verif/tb.sv
module tb;
	import tsa_pkg::*;

	// Mode code that the block must ignore.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	// Phase number of the discovery phase; slot phases follow it.
	localparam int DISCOVERY = 0;
	localparam int POOL = 8;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_style_t;

	logic clk = 1'b0;
	logic arst_n;

	tsa_cfg_if cfg_if();
	tsa_in_if  req_if();
	tsa_out_if rsp_if();

	tdma_slot_allocator_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #6 clk = ~clk;

	// Scheduler mirror: phase pointer, slot table and counters as the block
	// should hold them after every accepted item.
	int               sch_phase;
	bit               sch_await;
	bit               slot_busy [SLOTS];
	logic [ADDR_W-1:0] slot_tag [SLOTS];
	logic [MISS_W-1:0] slot_misses [SLOTS];
	bit               slot_leave [SLOTS];
	int               slots_free;
	logic [SEQ_W-1:0] frame_seq;
	bit               occ_flag;
	logic [MISS_W-1:0] miss_limit_q;

	// Results owed by the block, oldest first.
	result_t sched_results_q[$];
	result_t want;
	int mismatches = 0;

	// Stimulus controls shared by the tests, the sender and the receiver.
	logic [ADDR_W-1:0] addr_pool [POOL];
	bit        sender_gaps = 1'b0;
	int        burst_left = 0;
	rx_style_t rx_style = RX_ALWAYS;
	bit        hold_off_req = 1'b0;
	int        idle_cycles = 0;

	function automatic void advance_phase();
		sch_phase = (sch_phase >= SLOTS) ? DISCOVERY : sch_phase + 1;
	endfunction

	function automatic void launch_frame(inout result_t r, input logic [CMD_W-1:0] cmd,
			input logic [ADDR_W-1:0] dest);
		r.send_frame      = 1'b1;
		r.frame_command   = cmd;
		r.target_address  = dest;
		r.sequence_number = frame_seq;
		frame_seq++;
		sch_await = 1'b1;
	endfunction

	function automatic void report_event(inout result_t r, input logic [EV_W-1:0] kind,
			input logic [ADDR_W-1:0] addr, input int slot_num);
		r.event_valid   = 1'b1;
		r.event_kind    = kind;
		r.event_address = addr;
		r.event_slot    = EV_SLOT_W'(slot_num);
	endfunction

	function automatic void release_slot(input int s);
		slot_busy[s]   = 1'b0;
		slot_tag[s]    = '0;
		slot_misses[s] = '0;
		slot_leave[s]  = 1'b0;
		slots_free++;
	endfunction

	// Work out the result of one accepted item and move the mirror forward.
	function automatic result_t schedule_step(input logic [MODE_W-1:0] mode, input logic ok,
			input logic [ADDR_W-1:0] raddr, input logic [ADDR_W-1:0] dtarget);
		result_t r;
		int s;
		bit hit;
		r = '0;
		case (mode)
			MODE_TICK: begin
				// A tick while an exchange is outstanding is dropped.
				if (!sch_await) begin
					if (sch_phase == DISCOVERY) begin
						occ_flag = (slots_free < SLOTS);
						if (slots_free != 0)
							launch_frame(r, FRAME_NEW, '0);
						else
							advance_phase();
					end else begin
						s = sch_phase - 1;
						if (slot_busy[s])
							launch_frame(r, slot_leave[s] ? FRAME_DELETE : FRAME_UPDATE,
								slot_tag[s]);
						else
							advance_phase();
					end
				end
			end
			MODE_OUTCOME: begin
				if (sch_await) begin
					sch_await = 1'b0;
					if (sch_phase == DISCOVERY) begin
						if (ok) begin
							// Drop a responder that already owns a slot.
							hit = 1'b0;
							for (int i = 0; i < SLOTS; i++)
								if (slot_busy[i] && slot_tag[i] == raddr)
									hit = 1'b1;
							for (int i = 0; i < SLOTS; i++) begin
								if (!hit && !slot_busy[i]) begin
									hit            = 1'b1;
									slot_busy[i]   = 1'b1;
									slot_tag[i]    = raddr;
									slot_misses[i] = '0;
									slot_leave[i]  = 1'b0;
									if (slots_free != 0)
										slots_free--;
									report_event(r, EV_NEW, raddr, 0);
								end
							end
						end
					end else begin
						s = sch_phase - 1;
						if (slot_busy[s]) begin
							if (ok) begin
								slot_misses[s] = '0;
								if (slot_leave[s])
									release_slot(s);
								else
									report_event(r, EV_UPDATE, slot_tag[s], s + 1);
							end else begin
								if (slot_misses[s] < MISS_MAX)
									slot_misses[s]++;
								if (slot_misses[s] >= miss_limit_q) begin
									// Report the tag before the slot is wiped.
									report_event(r, EV_REMOVED, slot_tag[s], s + 1);
									release_slot(s);
								end
							end
						end
					end
					advance_phase();
				end
			end
			MODE_DELETE: begin
				hit = 1'b0;
				for (int i = 0; i < SLOTS; i++) begin
					if (!hit && slot_busy[i] && slot_tag[i] == dtarget) begin
						hit           = 1'b1;
						slot_leave[i] = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.occupied_indicator = occ_flag;
		return r;
	endfunction

	// Offer one item, hold it until the block takes it, then apply sender idling.
	task automatic send_item(input logic [MODE_W-1:0] mode, input logic ok,
			input logic [ADDR_W-1:0] raddr, input logic [ADDR_W-1:0] dtarget);
		int gap;
		@(negedge clk);
		req_if.valid             <= 1'b1;
		req_if.mode              <= mode;
		req_if.exchange_ok       <= ok;
		req_if.responder_address <= raddr;
		req_if.delete_target     <= dtarget;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sched_results_q.push_back(schedule_step(mode, ok, raddr, dtarget));
		if (sender_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(1, 6);
				repeat (gap) begin
					@(negedge clk);
					req_if.valid <= 1'b0;
				end
			end else begin
				burst_left--;
			end
		end
	endtask

	// Stop offering and wait until every owed result has been transferred.
	task automatic drain_results();
		@(negedge clk);
		req_if.valid <= 1'b0;
		burst_left = 0;
		while (sched_results_q.size() != 0)
			@(posedge clk);
		// Then let the block settle.
		repeat (2) @(posedge clk);
	endtask

	task automatic write_miss_limit(input logic [MISS_W-1:0] value);
		drain_results();
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		miss_limit_q = value;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Mostly well-formed tick/outcome rounds, seasoned with delete requests
	// aimed mostly at tags in the table and with out-of-order noise.
	task automatic run_traffic(input int n_items, input int miss_pct);
		logic [MODE_W-1:0] mode;
		logic ok;
		logic [ADDR_W-1:0] raddr;
		logic [ADDR_W-1:0] dtarget;
		int pick;
		int s;
		for (int i = 2; i < POOL; i++)
			addr_pool[i] = {$urandom, $urandom};
		repeat (n_items) begin
			pick    = $urandom_range(0, 99);
			ok      = 1'($urandom_range(0, 1));
			raddr   = {$urandom, $urandom};
			dtarget = {$urandom, $urandom};
			if (pick < 8) begin
				mode = MODE_W'($urandom_range(0, 3));
			end else if (pick < 14) begin
				mode = MODE_DELETE;
				s = $urandom_range(0, SLOTS - 1);
				if (slot_busy[s] && $urandom_range(0, 3) != 0)
					dtarget = slot_tag[s];
				else
					dtarget = addr_pool[$urandom_range(0, POOL - 1)];
			end else if (sch_await) begin
				mode = MODE_OUTCOME;
				if (sch_phase == DISCOVERY) begin
					ok    = ($urandom_range(0, 99) < 75);
					raddr = addr_pool[$urandom_range(0, POOL - 1)];
				end else begin
					ok = ($urandom_range(0, 99) >= miss_pct);
				end
			end else begin
				mode = MODE_TICK;
			end
			send_item(mode, ok, raddr, dtarget);
		end
	endtask

	// Walk the special cases by hand at the reset miss limit.
	task automatic test_directed_cases();
		sender_gaps = 1'b0;
		rx_style = RX_ALWAYS;
		send_item(MODE_TICK, 1'b0, '0, '0);       // broadcast, no tags yet
		send_item(MODE_OUTCOME, 1'b1, '1, '0);    // join into slot 1
		send_item(MODE_TICK, 1'b0, '0, '0);       // update frame to slot 1
		send_item(MODE_OUTCOME, 1'b1, '0, '1);    // update done
		send_item(MODE_TICK, 1'b0, '1, '1);       // empty slot 2 skips
		send_item(MODE_TICK, 1'b0, '0, '0);       // empty slot 3 skips
		send_item(MODE_TICK, 1'b0, '0, '0);       // broadcast, indicator set
		send_item(MODE_OUTCOME, 1'b1, '1, '0);    // duplicate responder
		send_item(MODE_TICK, 1'b0, '0, '0);       // update frame to slot 1
		send_item(MODE_TICK, 1'b1, '1, '1);       // tick while waiting
		send_item(MODE_OUTCOME, 1'b0, '1, '0);    // first miss
		send_item(MODE_OUTCOME, 1'b1, '1, '1);    // outcome while not waiting
		send_item(MODE_UNUSED, 1'b1, '1, '1);     // unknown mode
		send_item(MODE_TICK, 1'b0, '0, '0);
		send_item(MODE_TICK, 1'b0, '0, '0);
		send_item(MODE_TICK, 1'b0, '0, '0);       // broadcast
		send_item(MODE_OUTCOME, 1'b0, 64'h5A5A_0F0F_A5A5_F0F0, '0); // failed discovery
		send_item(MODE_TICK, 1'b0, '0, '0);       // update frame to slot 1
		send_item(MODE_DELETE, 1'b0, '0, '1);     // mark taken while waiting
		send_item(MODE_OUTCOME, 1'b1, '0, '0);    // handled as delete, no event
		send_item(MODE_DELETE, 1'b1, '1, 64'h0123_4567_89AB_CDEF); // no match
		send_item(MODE_TICK, 1'b0, '0, '0);
		send_item(MODE_TICK, 1'b0, '0, '0);
		send_item(MODE_TICK, 1'b0, '0, '0);       // broadcast, indicator clear
		send_item(MODE_OUTCOME, 1'b1, '0, '0);    // zero address joins
	endtask

	// A single miss frees a slot.
	task automatic test_fast_removal();
		write_miss_limit(4'd1);
		sender_gaps = 1'b1;
		rx_style = RX_RANDOM;
		run_traffic(200, 40);
	endtask

	// Only a long run of misses frees a slot; miss counts saturate.
	task automatic test_slow_removal();
		write_miss_limit(4'd15);
		sender_gaps = 1'b1;
		rx_style = RX_PATTERN;
		run_traffic(280, 95);
	endtask

	task automatic test_mid_limit();
		write_miss_limit(4'd6);
		sender_gaps = 1'b1;
		rx_style = RX_RANDOM;
		run_traffic(200, 50);
	endtask

	// Hold the receiver off while the sender keeps offering, then let it drain.
	task automatic test_backpressure();
		write_miss_limit(MISS_W'($urandom_range(1, 15)));
		sender_gaps = 1'b0;
		rx_style = RX_ALWAYS;
		hold_off_req = 1'b1;
		run_traffic(150, 25);
		// Pause until everything owed has come, then resume at full rate.
		drain_results();
		run_traffic(60, 25);
	endtask

	task automatic test_sparse_receiver();
		write_miss_limit(MISS_LIMIT_RST);
		sender_gaps = 1'b1;
		rx_style = RX_SPARSE;
		run_traffic(250, 35);
	endtask

	// Receiver: drive ready on its own pattern, with a long counted hold-off
	// whenever a test asks for one.
	initial begin
		int hold_left;
		int cycle_cnt;
		hold_left = 0;
		cycle_cnt = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			cycle_cnt++;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				case (rx_style)
					RX_ALWAYS:  rsp_if.ready <= 1'b1;
					RX_RANDOM:  rsp_if.ready <= ($urandom_range(0, 99) < 70);
					RX_PATTERN: rsp_if.ready <= ((cycle_cnt % 7) < 4);
					default:    rsp_if.ready <= ($urandom_range(0, 99) < 25);
				endcase
			end
		end
	end

	task automatic check_field(input string name, input logic [ADDR_W-1:0] exp_val,
			input logic [ADDR_W-1:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got_val);
			mismatches++;
		end
	endtask

	// Compare each transferred result with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (sched_results_q.size() == 0) begin
				$error("result transferred with none expected");
				mismatches++;
			end else begin
				want = sched_results_q.pop_front();
				check_field("send_frame", ADDR_W'(want.send_frame),
					ADDR_W'(rsp_if.send_frame));
				check_field("frame_command", ADDR_W'(want.frame_command),
					ADDR_W'(rsp_if.frame_command));
				check_field("target_address", want.target_address, rsp_if.target_address);
				check_field("sequence_number", ADDR_W'(want.sequence_number),
					ADDR_W'(rsp_if.sequence_number));
				check_field("event_valid", ADDR_W'(want.event_valid),
					ADDR_W'(rsp_if.event_valid));
				check_field("event_kind", ADDR_W'(want.event_kind),
					ADDR_W'(rsp_if.event_kind));
				check_field("event_address", want.event_address, rsp_if.event_address);
				check_field("event_slot", ADDR_W'(want.event_slot),
					ADDR_W'(rsp_if.event_slot));
				check_field("occupied_indicator", ADDR_W'(want.occupied_indicator),
					ADDR_W'(rsp_if.occupied_indicator));
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tdma_slot_allocator_core test failed");
			$finish;
		end
	end

	initial begin
		// Mirror starts in its reset state.
		sch_phase    = DISCOVERY;
		sch_await    = 1'b0;
		slots_free   = SLOTS;
		frame_seq    = '0;
		occ_flag     = 1'b0;
		miss_limit_q = MISS_LIMIT_RST;
		for (int i = 0; i < SLOTS; i++) begin
			slot_busy[i]   = 1'b0;
			slot_tag[i]    = '0;
			slot_misses[i] = '0;
			slot_leave[i]  = 1'b0;
		end
		addr_pool[0] = '0;
		addr_pool[1] = '1;

		arst_n                   = 1'b0;
		req_if.valid             = 1'b0;
		req_if.mode              = MODE_TICK;
		req_if.exchange_ok       = 1'b0;
		req_if.responder_address = '0;
		req_if.delete_target     = '0;
		cfg_if.valid             = 1'b0;
		cfg_if.data              = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_fast_removal();
		test_slow_removal();
		test_mid_limit();
		test_backpressure();
		test_sparse_receiver();

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tdma_slot_allocator_core test passed");
		else
			$display("tdma_slot_allocator_core test failed");
		$finish;
	end

endmodule
